[rtl/fss_pkg.sv]
// fss_pkg: shared types, constants and helper functions of the fuzzy
// subsequence scorer. No dependencies.
package fss_pkg;

  localparam int unsigned MaxQueryLenDefault = 32;

  localparam int unsigned CharW     = 8;
  localparam int unsigned QposW     = 6;
  localparam int unsigned SumW      = 10;
  localparam int unsigned LenW      = 5;
  localparam int unsigned ScoreW    = 11;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned BytesPerReg = CfgDataW / CharW;

  localparam logic [SumW-1:0]   BonusMatch = SumW'(10);
  localparam logic [SumW-1:0]   BonusRun   = SumW'(5);
  localparam logic [SumW-1:0]   BonusWord  = SumW'(8);
  localparam logic [LenW-1:0]   LenCap     = LenW'(20);
  localparam logic [ScoreW-1:0] ScoreMiss  = '1;   // -1

  localparam logic [CharW-1:0] ChHyphen = 8'h2D;
  localparam logic [CharW-1:0] ChUscore = 8'h5F;
  localparam logic [CharW-1:0] ChSpace  = 8'h20;
  localparam logic [CharW-1:0] ChUpperA = 8'h41;
  localparam logic [CharW-1:0] ChUpperZ = 8'h5A;
  localparam logic [CharW-1:0] CaseOfs  = 8'h20;

  typedef enum logic [CfgIdxW-1:0] {
    REG_QUERY_LEN     = 3'd0,
    REG_QUERY_BYTES_0 = 3'd1,
    REG_QUERY_BYTES_1 = 3'd2,
    REG_QUERY_BYTES_2 = 3'd3,
    REG_QUERY_BYTES_3 = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [CharW-1:0] text_char;
    logic             empty_text;
    logic             last_char;
  } item_t;

  typedef struct packed {
    logic signed [ScoreW-1:0] score;
    logic                     matched;
  } result_t;

  // ASCII A-Z folded to lower case, everything else unchanged
  function automatic logic [CharW-1:0] fold_case(input logic [CharW-1:0] c);
    logic [CharW-1:0] r;
    r = c;
    if (c >= ChUpperA && c <= ChUpperZ) begin
      r = c + CaseOfs;
    end
    return r;
  endfunction

  function automatic logic is_boundary(input logic [CharW-1:0] c);
    return (c == ChHyphen) || (c == ChUscore) || (c == ChSpace);
  endfunction

endpackage

[rtl/fuzzy_subsequence_scorer_unit.sv]
// Fuzzy subsequence scorer, top level: input register, match core,
// result register. Depends on fss_pkg, fss_cfg_regs, fss_match_core.
// A result is loaded into the result register when the final (or empty-text)
// byte leaves the input register. Throughput: one byte per cycle; a final byte
// only waits while the receiver still holds the previous result.
// Reset (rst_ni, async, active low) clears query registers, match state
// and both valid flags; the block is usable on the first cycle after it.
module fuzzy_subsequence_scorer_unit #(
  parameter int unsigned MAX_QUERY_LEN = fss_pkg::MaxQueryLenDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // text bytes in
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] text_char
  input  logic                          s_axis_tlast,   // last_char
  input  logic                          s_axis_tuser,   // empty_text
  // scores out
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [15:0]                   m_axis_tdata,   // [10:0] score, rest zero
  output logic                          m_axis_tuser,   // matched
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fss_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [fss_pkg::CfgDataW-1:0]  cfg_data_i
);
  import fss_pkg::*;

  logic [QposW-1:0]                    query_len;
  logic [MAX_QUERY_LEN-1:0][CharW-1:0] query_bytes;

  // Configuration is always taken; writes to unknown indexes are dropped
  assign cfg_ready_o = 1'b1;

  fss_cfg_regs #(
    .MAX_QUERY_LEN (MAX_QUERY_LEN)
  ) u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .wr_en_i       (cfg_valid_i),
    .wr_idx_i      (cfg_index_i),
    .wr_data_i     (cfg_data_i),
    .query_len_o   (query_len),
    .query_bytes_o (query_bytes)
  );

  // Input register stage
  logic    in_valid_q;
  item_t   in_item_q;
  logic    out_valid_q;
  result_t out_q;
  result_t core_res;
  logic    out_free, emit, advance;

  assign out_free = !out_valid_q || m_axis_tready;
  assign emit     = in_item_q.empty_text || in_item_q.last_char;
  // A byte that produces no result never waits for the output side
  assign advance  = in_valid_q && (!emit || out_free);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q.text_char  <= s_axis_tdata;
      in_item_q.empty_text <= s_axis_tuser;
      in_item_q.last_char  <= s_axis_tlast;
    end
  end

  fss_match_core #(
    .MAX_QUERY_LEN (MAX_QUERY_LEN)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .item_i        (in_item_q),
    .query_len_i   (query_len),
    .query_bytes_i (query_bytes),
    .result_o      (core_res)
  );

  // Result register: loads as soon as the old result is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_q <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_q.score};
  assign m_axis_tuser  = out_q.matched;

endmodule

[rtl/fss_cfg_regs.sv]
// fss_cfg_regs: query length and query byte registers, written through
// the configuration channel. Depends on fss_pkg.
module fss_cfg_regs #(
  parameter int unsigned MAX_QUERY_LEN = fss_pkg::MaxQueryLenDefault
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   wr_en_i,
  input  logic [fss_pkg::CfgIdxW-1:0]            wr_idx_i,
  input  logic [fss_pkg::CfgDataW-1:0]           wr_data_i,
  output logic [fss_pkg::QposW-1:0]              query_len_o,
  output logic [MAX_QUERY_LEN-1:0][fss_pkg::CharW-1:0] query_bytes_o
);
  import fss_pkg::*;

  logic [QposW-1:0] query_len_q;
  logic [MAX_QUERY_LEN-1:0][CharW-1:0] query_bytes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_len_q <= '0;
    end else if (wr_en_i && (wr_idx_i == REG_QUERY_LEN)) begin
      query_len_q <= wr_data_i[QposW-1:0];
    end
  end

  // Only the bytes the block can ever use are kept
  for (genvar j = 0; j < MAX_QUERY_LEN; j++) begin : g_byte
    localparam int unsigned RegOfs = j / BytesPerReg;
    localparam int unsigned ByteOfs = j % BytesPerReg;
    logic hit;
    assign hit = wr_en_i &&
                 (wr_idx_i == CfgIdxW'(int'(REG_QUERY_BYTES_0) + RegOfs));
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        query_bytes_q[j] <= '0;
      end else if (hit) begin
        query_bytes_q[j] <= wr_data_i[ByteOfs*CharW +: CharW];
      end
    end
  end

  assign query_len_o   = query_len_q;
  assign query_bytes_o = query_bytes_q;

endmodule

[rtl/fss_match_core.sv]
// fss_match_core: per-text match state and the single-pass update that
// scores one text byte. Depends on fss_pkg.
module fss_match_core #(
  parameter int unsigned MAX_QUERY_LEN = fss_pkg::MaxQueryLenDefault
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   step_i,
  input  fss_pkg::item_t                         item_i,
  input  logic [fss_pkg::QposW-1:0]              query_len_i,
  input  logic [MAX_QUERY_LEN-1:0][fss_pkg::CharW-1:0] query_bytes_i,
  output fss_pkg::result_t                       result_o
);
  import fss_pkg::*;

  localparam int unsigned QidxW = (MAX_QUERY_LEN > 1) ? $clog2(MAX_QUERY_LEN) : 1;

  logic [QposW-1:0] qpos_q, qpos_d;
  logic             prev_q, prev_d;
  logic             bound_q, bound_d;
  logic [SumW-1:0]  sum_q, sum_d;
  logic [LenW-1:0]  len_q, len_d;

  logic [QposW-1:0] n_act;
  logic             active, hit, finish;
  logic [SumW-1:0]  add;
  logic [CharW-1:0] qchar;

  always_comb begin
    n_act = (query_len_i > QposW'(MAX_QUERY_LEN)) ? QposW'(MAX_QUERY_LEN) : query_len_i;
    active = qpos_q < n_act;
    qchar  = query_bytes_i[qpos_q[QidxW-1:0]];
    hit    = active && (fold_case(qchar) == fold_case(item_i.text_char));

    add = BonusMatch;
    if (prev_q)  add = add + BonusRun;
    if (bound_q) add = add + BonusWord;

    sum_d   = hit ? (sum_q + add) : sum_q;
    qpos_d  = qpos_q + QposW'(hit);
    prev_d  = active ? hit : prev_q;
    bound_d = is_boundary(item_i.text_char);
    len_d   = (len_q < LenCap) ? (len_q + LenW'(1)) : len_q;

    finish = item_i.empty_text || item_i.last_char;

    // Result as seen after this byte; an empty text scores a cleared state
    if (n_act == '0) begin
      result_o.score   = '0;
      result_o.matched = 1'b1;
    end else if (item_i.empty_text || (qpos_d < n_act)) begin
      result_o.score   = ScoreMiss;
      result_o.matched = 1'b0;
    end else begin
      result_o.score   = ScoreW'({1'b0, sum_d}) +
                         (ScoreW'(LenCap) - ScoreW'(len_d));
      result_o.matched = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qpos_q  <= '0;
      prev_q  <= 1'b0;
      bound_q <= 1'b1;
      sum_q   <= '0;
      len_q   <= '0;
    end else if (step_i) begin
      if (finish) begin
        qpos_q  <= '0;
        prev_q  <= 1'b0;
        bound_q <= 1'b1;
        sum_q   <= '0;
        len_q   <= '0;
      end else begin
        qpos_q  <= qpos_d;
        prev_q  <= prev_d;
        bound_q <= bound_d;
        sum_q   <= sum_d;
        len_q   <= len_d;
      end
    end
  end

endmodule
